[src/roc_pkg.sv]
`timescale 1ns / 1ps

package roc_pkg;

  // Field widths of the cell-range coordinates and the merge type.
  localparam int ROW_W  = 21;
  localparam int COL_W  = 15;
  localparam int KIND_W = 8;

  // One stored rectangle: row range then column range.
  localparam int ENTRY_W = 2 * ROW_W + 2 * COL_W;

  // Default table depth.
  localparam int MAX_RECTS_DEF = 64;

  // Merge type codes written over the incoming value.
  localparam logic [KIND_W-1:0] KIND_BOTH     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_ROW_ONLY = KIND_W'(2);

  typedef struct packed {
    logic              first_of_set;
    logic [ROW_W-1:0]  row_start;
    logic [ROW_W-1:0]  row_last;
    logic [COL_W-1:0]  col_start;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  rows_spanned;
    logic [COL_W-1:0]  cols_spanned;
    logic [KIND_W-1:0] kind_in;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind_out;
    logic              is_inside;
    logic              must_resolve;
    logic              store_full;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_start;
    logic [ROW_W-1:0] row_last;
    logic [COL_W-1:0] col_start;
    logic [COL_W-1:0] col_last;
  } rect_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take a new item
    logic scan;    // walk the stored table
    logic commit;  // store the rectangle and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

[src/roc_ram.sv]
`timescale 1ns / 1ps

module roc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/roc_ctrl.sv]
`timescale 1ns / 1ps

module roc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  roc_pkg::dp_status_t status,
  output roc_pkg::ctrl_cmd_t  cmd
);

  import roc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Result valid flag: set on commit, cleared once the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/roc_datapath.sv]
`timescale 1ns / 1ps

module roc_datapath #(
  parameter int MAX_RECTS = roc_pkg::MAX_RECTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  roc_pkg::in_item_t   in_data,
  input  roc_pkg::ctrl_cmd_t  cmd,
  output roc_pkg::dp_status_t status,
  output roc_pkg::out_item_t  out_data
);

  import roc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_RECTS);
  localparam int CNT_W  = $clog2(MAX_RECTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);

  rect_t             rect_r, rect_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              inside_r, inside_nxt;
  logic              resolve_r, resolve_nxt;
  out_item_t         out_r, out_nxt;

  logic              rd_en;
  logic              wr_en;
  logic              full;
  logic [ENTRY_W-1:0] rd_word;
  rect_t             entry;
  logic              contains;
  logic              overlaps;
  logic              hit_now;
  logic [ROW_W-1:0]  row_lo;
  logic [ROW_W-1:0]  row_hi;
  logic [COL_W-1:0]  col_lo;
  logic [COL_W-1:0]  col_hi;

  // Stored rectangles, one word per entry.
  roc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RECTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (rect_r),
    .re    (rd_en),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rd_word)
  );

  assign entry = rect_t'(rd_word);

  // Containment and overlap of the item against the entry just read.
  always_comb begin
    row_lo   = (rect_r.row_start > entry.row_start) ? rect_r.row_start : entry.row_start;
    row_hi   = (rect_r.row_last < entry.row_last) ? rect_r.row_last : entry.row_last;
    col_lo   = (rect_r.col_start > entry.col_start) ? rect_r.col_start : entry.col_start;
    col_hi   = (rect_r.col_last < entry.col_last) ? rect_r.col_last : entry.col_last;
    contains = (rect_r.row_start >= entry.row_start) && (rect_r.row_last <= entry.row_last) &&
               (rect_r.col_start >= entry.col_start) && (rect_r.col_last <= entry.col_last);
    overlaps = (row_lo <= row_hi) && (col_lo <= col_hi);
    hit_now  = cmd.scan && pend_r && (contains || overlaps);
  end

  // Table walk: one read issued per cycle, compared the cycle after.
  assign rd_en            = cmd.scan && (idx_r < cnt_r) && !hit_now;
  assign status.scan_done = hit_now || (!pend_r && (idx_r == cnt_r));

  assign full  = (cnt_r >= CNT_MAX);
  assign wr_en = cmd.commit && !full;

  // Merge type rewritten from the span counts; otherwise the incoming type is kept.
  function automatic logic [KIND_W-1:0] merge_kind(in_item_t it);
    logic rows_multi;
    rows_multi = (it.rows_spanned > ROW_W'(1));
    if (rows_multi && (it.cols_spanned > COL_W'(1))) begin
      return KIND_BOTH;
    end else if (rows_multi && (it.cols_spanned == '0)) begin
      return KIND_ROW_ONLY;
    end
    return it.kind_in;
  endfunction

  // Next values of the item, walk and result registers.
  always_comb begin
    rect_nxt    = rect_r;
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pend_nxt    = cmd.scan ? rd_en : 1'b0;
    inside_nxt  = inside_r;
    resolve_nxt = resolve_r;
    out_nxt     = out_r;
    if (cmd.load) begin
      rect_nxt.row_start = in_data.row_start;
      rect_nxt.row_last  = in_data.row_last;
      rect_nxt.col_start = in_data.col_start;
      rect_nxt.col_last  = in_data.col_last;
      kind_nxt           = merge_kind(in_data);
      idx_nxt            = '0;
      inside_nxt         = 1'b0;
      resolve_nxt        = 1'b0;
      if (in_data.first_of_set) begin
        cnt_nxt = '0;
      end
    end
    if (rd_en) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (hit_now) begin
      inside_nxt  = contains;
      resolve_nxt = !contains;
    end
    if (cmd.commit) begin
      out_nxt.kind_out     = kind_r;
      out_nxt.is_inside    = inside_r;
      out_nxt.must_resolve = resolve_r;
      out_nxt.store_full   = full;
      if (!full) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    rect_r    <= rect_nxt;
    kind_r    <= kind_nxt;
    inside_r  <= inside_nxt;
    resolve_r <= resolve_nxt;
    out_r     <= out_nxt;
  end

  assign out_data = out_r;

endmodule

[src/rect_overlap_classifier.sv]
`timescale 1ns / 1ps

// Rectangle overlap classifier. Each cell-range rectangle taken on the input
// channel has its merge type rewritten from its span counts and is compared,
// in storage order, with the rectangles stored earlier in the current set; the
// first stored rectangle that contains it or overlaps it sets is_inside or
// must_resolve. The rectangle is then appended to the table, or store_full is
// raised when the table already holds MAX_RECTS entries. first_of_set empties
// the table before the item is handled. Items are handled one at a time; the
// walk over the table ends early when a hit is found. The block is ready for
// the next item in the same cycle that the result becomes valid. The time per
// item is set by the walk over the table memory, which has one read port and
// is read one entry per cycle. A finished result waits in an output register,
// so the next item can be taken while the result has not yet been transferred.
module rect_overlap_classifier #(
  parameter int MAX_RECTS = roc_pkg::MAX_RECTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  roc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output roc_pkg::out_item_t out_data
);

  import roc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  roc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table, comparators and result register.
  roc_datapath #(
    .MAX_RECTS (MAX_RECTS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
